FILE: hdl/water_heater_thermostat_unit_assert.svh
// Assertion macros shared by the thermostat modules.
// Expects signals named clk and rst_n in the including module.
`ifndef WATER_HEATER_THERMOSTAT_UNIT_ASSERT_SVH
`define WATER_HEATER_THERMOSTAT_UNIT_ASSERT_SVH

// Condition in the same cycle implies a consequence in that cycle.
`define WHT_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("thermostat check failed");

// Condition in one cycle implies a consequence in the next cycle.
`define WHT_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("thermostat check failed");

`endif

FILE: hdl/wht_pkg.sv
// Shared types and constants for the water heater thermostat.
// Used by wht_core and water_heater_thermostat_unit; depends on nothing.
package wht_pkg;

    // Event kinds carried on the input stream.
    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_SAMPLE = 2'd1,
        CMD_UP     = 2'd2,
        CMD_DOWN   = 2'd3
    } cmd_t;

    // Configuration register indexes.
    localparam logic [2:0] REG_BAND          = 3'd0;
    localparam logic [2:0] REG_STEP_SIZE     = 3'd1;
    localparam logic [2:0] REG_SETPOINT_MIN  = 3'd2;
    localparam logic [2:0] REG_SETPOINT_MAX  = 3'd3;
    localparam logic [2:0] REG_TIMEOUT_TICKS = 3'd4;

    // Configuration reset values.
    localparam logic [4:0]  BAND_RESET          = 5'd5;
    localparam logic [4:0]  STEP_SIZE_RESET     = 5'd5;
    localparam logic [6:0]  SETPOINT_MIN_RESET  = 7'd25;
    localparam logic [6:0]  SETPOINT_MAX_RESET  = 7'd75;
    localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd5000;

    // Setpoint after reset.
    localparam logic [6:0] TARGET_RESET = 7'd60;

    typedef struct packed {
        logic [4:0]  band;
        logic [4:0]  step_size;
        logic [6:0]  setpoint_min;
        logic [6:0]  setpoint_max;
        logic [15:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic       heater_on;
        logic       set_mode;
        logic [6:0] setpoint;
        logic [7:0] average_temp;
        logic [7:0] display_value;
    } result_t;

endpackage

FILE: hdl/water_heater_thermostat_unit.sv
// Top level of the water heater thermostat: stream ports, configuration
// registers and the output register. Depends on wht_pkg, wht_core and
// water_heater_thermostat_unit_assert.svh.
//
// The block takes one event word per clock (tick, temperature sample, up
// press or down press) and returns exactly one result word for each, in the
// cycle after it is taken. All state updates for an event finish in the
// cycle the word is accepted; the single output register then holds the
// result, and s_tready stays high as long as that register is empty or is
// being emptied in the same cycle, so the sustained rate is one word per
// clock when the downstream side keeps m_tready high. Configuration writes
// take effect on the next clock and are meant for idle periods only.
`include "water_heater_thermostat_unit_assert.svh"

module water_heater_thermostat_unit #(
    parameter int SAMPLES_PER_AVERAGE = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] sample
    input  logic [1:0]  s_tuser,   // [1:0] command
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] heater_on, [1] set_mode, [8:2] setpoint, [16:9] average_temp,
    // [24:17] display_value, [31:25] zero
    output logic [31:0] m_tdata,
    // Configuration writes.
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    wht_pkg::cfg_t    cfg_reg;
    wht_pkg::result_t core_result;
    logic             accept;
    logic             out_valid_reg, out_valid_next;
    logic [31:0]      out_data_reg;

    // Configuration register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.band          <= wht_pkg::BAND_RESET;
            cfg_reg.step_size     <= wht_pkg::STEP_SIZE_RESET;
            cfg_reg.setpoint_min  <= wht_pkg::SETPOINT_MIN_RESET;
            cfg_reg.setpoint_max  <= wht_pkg::SETPOINT_MAX_RESET;
            cfg_reg.timeout_ticks <= wht_pkg::TIMEOUT_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                wht_pkg::REG_BAND:          cfg_reg.band          <= cfg_data[4:0];
                wht_pkg::REG_STEP_SIZE:     cfg_reg.step_size     <= cfg_data[4:0];
                wht_pkg::REG_SETPOINT_MIN:  cfg_reg.setpoint_min  <= cfg_data[6:0];
                wht_pkg::REG_SETPOINT_MAX:  cfg_reg.setpoint_max  <= cfg_data[6:0];
                wht_pkg::REG_TIMEOUT_TICKS: cfg_reg.timeout_ticks <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Handshake: take a word whenever the output register is free or draining.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    wht_core #(
        .SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (accept),
        .command (s_tuser),
        .sample  (s_tdata),
        .cfg     (cfg_reg),
        .result  (core_result)
    );

    assign out_valid_next = accept || (out_valid_reg && !m_tready);

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= {7'b0,
                             core_result.display_value,
                             core_result.average_temp,
                             core_result.setpoint,
                             core_result.set_mode,
                             core_result.heater_on};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Every accepted word produces a result word in the next cycle.
    `WHT_ASSERT_NEXT(a_result_follows, accept, m_tvalid)
    // Outside set mode the display shows the average.
    `WHT_ASSERT_NOW(a_display_avg, m_tvalid && !m_tdata[1], m_tdata[24:17] == m_tdata[16:9])
    // In set mode the display shows the setpoint.
    `WHT_ASSERT_NOW(a_display_set, m_tvalid && m_tdata[1],
        m_tdata[24:17] == {1'b0, m_tdata[8:2]})

endmodule

FILE: hdl/wht_core.sv
// Thermostat state and its update for one event word, computed combinationally and registered.
// Depends on wht_pkg and water_heater_thermostat_unit_assert.svh.
`include "water_heater_thermostat_unit_assert.svh"

module wht_core #(
    parameter int SAMPLES_PER_AVERAGE = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [1:0]       command,
    input  logic [7:0]       sample,
    input  wht_pkg::cfg_t    cfg,
    output wht_pkg::result_t result
);

    // Division of the running sum by the sample count, done as a multiply
    // by a rounded-up reciprocal. The shift keeps the error below one LSB
    // for every 12-bit sum.
    localparam int          DIV_SHIFT = 20;
    localparam logic [20:0] DIV_MULT  =
        21'((2 ** DIV_SHIFT + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE);
    localparam logic [3:0]  COUNT_LAST = 4'(SAMPLES_PER_AVERAGE);

    logic        mode_reg,    mode_next;
    logic [6:0]  target_reg,  target_next;
    logic [15:0] timeout_reg, timeout_next;
    logic [11:0] sum_reg,     sum_next;
    logic [3:0]  count_reg,   count_next;
    logic [7:0]  average_reg, average_next;
    logic        relay_reg,   relay_next;

    logic [11:0] sum_add;
    logic [3:0]  count_add;
    logic [32:0] quot_prod;
    logic [7:0]  average_calc;
    logic [15:0] timeout_inc;
    logic [7:0]  target_up;
    logic [7:0]  down_floor;
    logic        below_band;
    logic        above_band;
    wht_pkg::cmd_t cmd;

    assign cmd = wht_pkg::cmd_t'(command);

    // Sample accumulation and average.
    assign sum_add      = sum_reg + {4'b0, sample};
    assign count_add    = count_reg + 4'd1;
    assign quot_prod    = {21'b0, sum_add} * {12'b0, DIV_MULT};
    assign average_calc = quot_prod[DIV_SHIFT +: 8];

    // Hysteresis compare, done without signed bounds.
    assign below_band = ({1'b0, average_calc} + {4'b0, cfg.band}) < {2'b0, target_reg};
    assign above_band = average_calc > ({1'b0, target_reg} + {3'b0, cfg.band});

    // Setpoint stepping and timeout count.
    assign target_up   = {1'b0, target_reg} + {3'b0, cfg.step_size};
    assign down_floor  = {1'b0, cfg.setpoint_min} + {3'b0, cfg.step_size};
    assign timeout_inc = timeout_reg + 16'd1;

    always_comb
    begin
        mode_next    = mode_reg;
        target_next  = target_reg;
        timeout_next = timeout_reg;
        sum_next     = sum_reg;
        count_next   = count_reg;
        average_next = average_reg;
        relay_next   = relay_reg;
        if (step)
        begin
            case (cmd)
                wht_pkg::CMD_TICK:
                begin
                    if (mode_reg)
                    begin
                        timeout_next = timeout_inc;
                        if (timeout_inc >= cfg.timeout_ticks || timeout_inc == 16'd0)
                        begin
                            mode_next    = 1'b0;
                            timeout_next = 16'd0;
                        end
                    end
                end
                wht_pkg::CMD_SAMPLE:
                begin
                    sum_next   = sum_add;
                    count_next = count_add;
                    if (count_add >= COUNT_LAST)
                    begin
                        average_next = average_calc;
                        sum_next     = 12'd0;
                        count_next   = 4'd0;
                        if (below_band)
                        begin
                            relay_next = 1'b1;
                        end
                        else if (above_band)
                        begin
                            relay_next = 1'b0;
                        end
                    end
                end
                wht_pkg::CMD_UP:
                begin
                    timeout_next = 16'd0;
                    if (!mode_reg)
                    begin
                        mode_next = 1'b1;
                    end
                    else if (target_reg < cfg.setpoint_max)
                    begin
                        target_next = (target_up > {1'b0, cfg.setpoint_max}) ?
                                      cfg.setpoint_max : target_up[6:0];
                    end
                end
                wht_pkg::CMD_DOWN:
                begin
                    timeout_next = 16'd0;
                    if (!mode_reg)
                    begin
                        mode_next = 1'b1;
                    end
                    else if (target_reg > cfg.setpoint_min)
                    begin
                        target_next = ({1'b0, target_reg} < down_floor) ?
                                      cfg.setpoint_min : (target_reg - {2'b0, cfg.step_size});
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 1'b0;
            target_reg  <= wht_pkg::TARGET_RESET;
            timeout_reg <= 16'd0;
            sum_reg     <= 12'd0;
            count_reg   <= 4'd0;
            average_reg <= 8'd0;
            relay_reg   <= 1'b0;
        end
        else
        begin
            mode_reg    <= mode_next;
            target_reg  <= target_next;
            timeout_reg <= timeout_next;
            sum_reg     <= sum_next;
            count_reg   <= count_next;
            average_reg <= average_next;
            relay_reg   <= relay_next;
        end
    end

    // Result word shows the state after this event.
    always_comb
    begin
        result.heater_on     = relay_next;
        result.set_mode      = mode_next;
        result.setpoint      = target_next;
        result.average_temp  = average_next;
        result.display_value = mode_next ? {1'b0, target_next} : average_next;
    end

    // The sample counter wraps before it reaches the average length.
    `WHT_ASSERT_NOW(a_count_range, 1'b1, count_reg < COUNT_LAST)
    // A tick in normal mode leaves the block in normal mode.
    `WHT_ASSERT_NEXT(a_tick_normal, step && cmd == wht_pkg::CMD_TICK && !mode_reg, !mode_reg)
    // The first press only enters set mode; the setpoint does not move.
    `WHT_ASSERT_NEXT(a_first_press,
        step && (cmd == wht_pkg::CMD_UP || cmd == wht_pkg::CMD_DOWN) && !mode_reg,
        mode_reg && $stable(target_reg) && timeout_reg == 16'd0)

endmodule

FILE: bench/wht_result_checker.sv
// Result checker for the water heater thermostat: watches the event, result and
// configuration ports, predicts every result word and compares it field by field.
// Depends on wht_pkg for the event kinds, register indexes and reset values.
module wht_result_checker #(
    parameter int SAMPLES_PER_AVERAGE = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] sample
    input  logic [1:0]  s_tuser,   // [1:0] command
    input  logic        m_tvalid,
    input  logic        m_tready,
    // [0] heater_on, [1] set_mode, [8:2] setpoint, [16:9] average_temp,
    // [24:17] display_value, [31:25] zero
    input  logic [31:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        run_done,
    output int          outstanding,
    output int          fail_count,
    output int          results_checked,
    output int          averages_formed
);

    // Local copy of the configuration registers.
    logic [4:0]  band_cfg;
    logic [4:0]  step_cfg;
    logic [6:0]  min_cfg;
    logic [6:0]  max_cfg;
    logic [15:0] timeout_cfg;

    // Predicted thermostat state.
    logic        in_set_mode;
    logic        relay;
    logic [6:0]  target;
    logic [15:0] idle_ticks;
    logic [11:0] temp_sum;
    logic [3:0]  temp_count;
    logic [7:0]  last_average;

    // Result words still owed by the block, oldest first.
    wht_pkg::result_t owed_results[$];
    wht_pkg::result_t predicted;
    wht_pkg::result_t want;
    int          errors = 0;
    int          checked = 0;
    int          averages = 0;
    bit          leftovers_checked = 1'b0;

    assign fail_count      = errors;
    assign results_checked = checked;
    assign averages_formed = averages;

    // One line per mismatch, and one more failure on the count.
    task automatic flag_mismatch(input string msg);
        $display("[%0t] thermostat mismatch: %s", $realtime, msg);
        errors++;
    endtask

    // Applies one event word to the predicted state and returns the result word.
    task automatic predict_result(input wht_pkg::cmd_t cmd, input logic [7:0] temp,
                                  output wht_pkg::result_t r);
        int stepped;
        int avg_i;
        case (cmd)
            wht_pkg::CMD_TICK:
            begin
                // Ticks only matter in set mode, where they run the timeout.
                if (in_set_mode)
                begin
                    idle_ticks = idle_ticks + 16'd1;
                    if (idle_ticks >= timeout_cfg || idle_ticks == 16'd0)
                    begin
                        in_set_mode = 1'b0;
                        idle_ticks  = '0;
                    end
                end
            end
            wht_pkg::CMD_SAMPLE:
            begin
                temp_sum   = temp_sum + 12'(temp);
                temp_count = temp_count + 4'd1;
                // A full set of samples forms an average and evaluates the relay.
                if (temp_count >= SAMPLES_PER_AVERAGE)
                begin
                    last_average = 8'(temp_sum / SAMPLES_PER_AVERAGE);
                    temp_sum     = '0;
                    temp_count   = '0;
                    averages++;
                    avg_i = int'(last_average);
                    if (avg_i < int'(target) - int'(band_cfg))
                        relay = 1'b1;
                    else if (avg_i > int'(target) + int'(band_cfg))
                        relay = 1'b0;
                end
            end
            default:
            begin
                // Any press restarts the timeout; the first one only enters set mode.
                idle_ticks = '0;
                if (!in_set_mode)
                    in_set_mode = 1'b1;
                else if (cmd == wht_pkg::CMD_UP)
                begin
                    if (target < max_cfg)
                    begin
                        stepped = int'(target) + int'(step_cfg);
                        target  = (stepped > int'(max_cfg)) ? max_cfg : 7'(stepped);
                    end
                end
                else if (target > min_cfg)
                begin
                    stepped = int'(target) - int'(step_cfg);
                    target  = (stepped < int'(min_cfg)) ? min_cfg : 7'(stepped);
                end
            end
        endcase
        r.heater_on     = relay;
        r.set_mode      = in_set_mode;
        r.setpoint      = target;
        r.average_temp  = last_average;
        r.display_value = in_set_mode ? {1'b0, target} : last_average;
    endtask

    // Predict on accepted events, check accepted results, follow register writes.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_cfg     = wht_pkg::BAND_RESET;
            step_cfg     = wht_pkg::STEP_SIZE_RESET;
            min_cfg      = wht_pkg::SETPOINT_MIN_RESET;
            max_cfg      = wht_pkg::SETPOINT_MAX_RESET;
            timeout_cfg  = wht_pkg::TIMEOUT_TICKS_RESET;
            in_set_mode  = 1'b0;
            relay        = 1'b0;
            target       = wht_pkg::TARGET_RESET;
            idle_ticks   = '0;
            temp_sum     = '0;
            temp_count   = '0;
            last_average = '0;
            owed_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_result(wht_pkg::cmd_t'(s_tuser), s_tdata, predicted);
                owed_results.push_back(predicted);
            end

            if (m_tvalid && m_tready)
            begin
                if (owed_results.size() == 0)
                    flag_mismatch($sformatf("result word 0x%08h arrived with none expected",
                                            m_tdata));
                else
                begin
                    want = owed_results.pop_front();
                    if (m_tdata[0] !== want.heater_on)
                        flag_mismatch($sformatf("word %0d heater_on got %0d, expected %0d",
                                                checked, m_tdata[0], want.heater_on));
                    if (m_tdata[1] !== want.set_mode)
                        flag_mismatch($sformatf("word %0d set_mode got %0d, expected %0d",
                                                checked, m_tdata[1], want.set_mode));
                    if (m_tdata[8:2] !== want.setpoint)
                        flag_mismatch($sformatf("word %0d setpoint got %0d, expected %0d",
                                                checked, m_tdata[8:2], want.setpoint));
                    if (m_tdata[16:9] !== want.average_temp)
                        flag_mismatch($sformatf("word %0d average_temp got %0d, expected %0d",
                                                checked, m_tdata[16:9], want.average_temp));
                    if (m_tdata[24:17] !== want.display_value)
                        flag_mismatch($sformatf("word %0d display_value got %0d, expected %0d",
                                                checked, m_tdata[24:17], want.display_value));
                    if (m_tdata[31:25] !== 7'd0)
                        flag_mismatch($sformatf("word %0d padding bits got 0x%02h",
                                                checked, m_tdata[31:25]));
                    checked++;
                end
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    wht_pkg::REG_BAND:          band_cfg    = cfg_data[4:0];
                    wht_pkg::REG_STEP_SIZE:     step_cfg    = cfg_data[4:0];
                    wht_pkg::REG_SETPOINT_MIN:  min_cfg     = cfg_data[6:0];
                    wht_pkg::REG_SETPOINT_MAX:  max_cfg     = cfg_data[6:0];
                    wht_pkg::REG_TIMEOUT_TICKS: timeout_cfg = cfg_data;
                    default:                    ;
                endcase
            end

            // At the end of the run nothing may still be owed.
            if (run_done && !leftovers_checked)
            begin
                leftovers_checked = 1'b1;
                if (owed_results.size() != 0)
                    flag_mismatch($sformatf("%0d result words never arrived",
                                            owed_results.size()));
            end

            outstanding <= owed_results.size();
        end
    end

endmodule

FILE: bench/tb.sv
// Testbench top for water_heater_thermostat_unit: clock, reset, event stimulus,
// result back-pressure, register writes and the final verdict.
// Depends on wht_pkg, the thermostat RTL and wht_result_checker.
module tb;

    localparam int SAMPLES_PER_AVERAGE = 10;
    localparam int CLK_PERIOD          = 8;
    localparam int LIMIT_CYCLES        = 600000;
    localparam int HOLDOFF_CYCLES      = 300;
    localparam int SETTLE_CYCLES       = 4;
    localparam int DRAIN_LIMIT         = 20000;
    localparam int LONG_TIMEOUT        = 80;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tready  = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;
    logic        run_done  = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [31:0] m_tdata;

    int outstanding;
    int fail_count;
    int results_checked;
    int averages_formed;

    // Idling controls and the long receiver hold-off request.
    int sender_idle_pct = 0;
    int stall_pct       = 0;
    int holdoff_asked   = 0;
    int holdoff_served  = 0;
    int holdoff_left    = 0;

    // Run statistics and the timeout currently programmed.
    int timeout_now   = wht_pkg::TIMEOUT_TICKS_RESET;
    int settings_used = 1;
    int events_sent   = 0;
    int ticks_sent    = 0;
    int samples_sent  = 0;
    int presses_sent  = 0;

    water_heater_thermostat_unit #(
        .SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    wht_result_checker #(
        .SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE)
    ) checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .run_done        (run_done),
        .outstanding     (outstanding),
        .fail_count      (fail_count),
        .results_checked (results_checked),
        .averages_formed (averages_formed)
    );

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // Result side: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge clk)
    begin
        if (holdoff_left > 0)
        begin
            holdoff_left <= holdoff_left - 1;
            m_tready     <= 1'b0;
        end
        else if (holdoff_served != holdoff_asked)
        begin
            holdoff_served <= holdoff_asked;
            holdoff_left   <= HOLDOFF_CYCLES - 1;
            m_tready       <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Offers one event word, with random idle cycles first, and waits for it.
    task automatic send_event(input wht_pkg::cmd_t cmd, input logic [7:0] temp);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= temp;
        do
            @(posedge clk);
        while (!s_tready);
        events_sent++;
        case (cmd)
            wht_pkg::CMD_TICK:   ticks_sent++;
            wht_pkg::CMD_SAMPLE: samples_sent++;
            default:             presses_sent++;
        endcase
    endtask

    // Stops offering words until every owed result word has come back.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] index, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= 16'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Programs all five registers while the block is idle.
    task automatic set_registers(input int band, input int step, input int lo,
                                 input int hi, input int timeout);
        wait_idle();
        write_register(wht_pkg::REG_BAND, band);
        write_register(wht_pkg::REG_STEP_SIZE, step);
        write_register(wht_pkg::REG_SETPOINT_MIN, lo);
        write_register(wht_pkg::REG_SETPOINT_MAX, hi);
        write_register(wht_pkg::REG_TIMEOUT_TICKS, timeout);
        timeout_now = timeout;
        settings_used++;
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        sender_idle_pct = sender_pct;
        stall_pct       <= receiver_pct;
    endtask

    // Random traffic: mostly whole averaging sets, press runs and tick runs,
    // with single random words mixed in as noise.
    task automatic run_random(input int count);
        int sent;
        int pick;
        int base;
        int len;
        int val;
        bit flat;
        bit go_up;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                // Ten samples around one temperature, so the average lands near it.
                base = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(140);
                flat = $urandom_range(1);
                repeat (SAMPLES_PER_AVERAGE)
                begin
                    val = flat ? base : base + $urandom_range(20) - 10;
                    if (val < 0)
                        val = 0;
                    if (val > 255)
                        val = 255;
                    send_event(wht_pkg::CMD_SAMPLE, 8'(val));
                end
                sent += SAMPLES_PER_AVERAGE;
            end
            else if (pick < 55)
            begin
                // A run of presses, mostly in one direction.
                len   = $urandom_range(6, 1);
                go_up = $urandom_range(1);
                repeat (len)
                begin
                    if ($urandom_range(4) == 0)
                        send_event(go_up ? wht_pkg::CMD_DOWN : wht_pkg::CMD_UP,
                                   8'($urandom));
                    else
                        send_event(go_up ? wht_pkg::CMD_UP : wht_pkg::CMD_DOWN,
                                   8'($urandom));
                end
                sent += len;
            end
            else if (pick < 75)
            begin
                // Ticks, long enough at times to end set mode.
                len = (timeout_now < 1) ? 1 : ((timeout_now > 40) ? 40 : timeout_now);
                len = $urandom_range(len + 2, 1);
                repeat (len)
                    send_event(wht_pkg::CMD_TICK, 8'($urandom));
                sent += len;
            end
            else
            begin
                send_event(wht_pkg::cmd_t'($urandom_range(3)), 8'($urandom));
                sent++;
            end
        end
    endtask

    // Overall time limit.
    initial
    begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("*** FAILED ***");
        $finish;
    end

    // Stimulus and verdict.
    initial
    begin
        int waited;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: idle tick, entering set mode, stepping up into the upper
        // limit, a down step, a tick in set mode, and one average taken in set
        // mode from extreme samples that switches the heater on.
        send_event(wht_pkg::CMD_TICK, 8'hFF);
        send_event(wht_pkg::CMD_UP, 8'h00);
        repeat (4)
            send_event(wht_pkg::CMD_UP, 8'h00);
        send_event(wht_pkg::CMD_DOWN, 8'h00);
        send_event(wht_pkg::CMD_TICK, 8'h00);
        send_event(wht_pkg::CMD_SAMPLE, 8'd0);
        send_event(wht_pkg::CMD_SAMPLE, 8'd255);
        repeat (SAMPLES_PER_AVERAGE - 2)
            send_event(wht_pkg::CMD_SAMPLE, 8'd0);

        // Reset settings, no idling on either side.
        run_random(150);

        // Zero band, unit step, full setpoint range, shortest timeout.
        set_registers(0, 1, 0, 127, 1);
        set_idling(51, 0);
        run_random(150);
        // Receiver holds off for a long stretch while words keep coming.
        set_idling(0, 0);
        holdoff_asked <= holdoff_asked + 1;
        run_random(40);
        wait_idle();

        // Band and step of 20, crossed limits, timeout of zero.
        set_registers(20, 20, 127, 0, 0);
        set_idling(0, 51);
        run_random(150);

        // Band and step at their field extremes, step of zero.
        set_registers(31, 0, 10, 100, 3);
        set_idling(6, 6);
        run_random(150);

        // Longer timeout: one press and then ticks until set mode ends.
        set_registers(7, 31, 0, 127, LONG_TIMEOUT);
        set_idling(0, 0);
        send_event(wht_pkg::CMD_UP, 8'h00);
        repeat (LONG_TIMEOUT)
            send_event(wht_pkg::CMD_TICK, 8'h00);
        send_event(wht_pkg::CMD_TICK, 8'h00);
        set_idling(51, 51);
        run_random(60);

        // Random settings across the idling patterns.
        for (int p = 0; p < 3; p++)
        begin
            set_registers($urandom_range(20), $urandom_range(20, 1), $urandom_range(127),
                          $urandom_range(127), $urandom_range(40, 1));
            case (p)
                0:       set_idling(51, 0);
                1:       set_idling(0, 51);
                default: set_idling(6, 6);
            endcase
            run_random(85);
        end

        // Let every owed result word come back.
        s_tvalid <= 1'b0;
        waited = 0;
        while (outstanding != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (waited >= DRAIN_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
        begin
            repeat (SETTLE_CYCLES) @(posedge clk);
            run_done <= 1'b1;
            repeat (2) @(posedge clk);
            $display("Summary: %0d events (%0d ticks, %0d samples, %0d presses)",
                     events_sent, ticks_sent, samples_sent, presses_sent);
            $display("Summary: %0d register settings, %0d words compared, %0d averages.",
                     settings_used, results_checked, averages_formed);
            if (fail_count == 0)
                $display("*** PASSED ***");
            else
                $display("*** FAILED ***");
            $finish;
        end
    end

endmodule
